### rtl/rsac_pkg.sv
// Package for the ranging sensor average and convert core.
// Holds widths, codes and the infrared reference tables; no dependencies.
package rsac_pkg;

    localparam int CHANNELS      = 4;
    localparam int CH_W          = $clog2(CHANNELS);
    localparam int SAMPLES       = 8;
    localparam int POS_W         = $clog2(SAMPLES);
    localparam int SAMPLE_W      = 10;
    localparam int SUM_W         = SAMPLE_W + POS_W;
    localparam int CNT_W         = POS_W + 1;
    localparam int MEM_DEPTH     = CHANNELS * SAMPLES;
    localparam int ADDR_W        = CH_W + POS_W;
    localparam int DIST_W        = 16;
    localparam int CODE_W        = SAMPLE_W - 2;
    localparam int CM_W          = 7;
    localparam int PROD_W        = DIST_W + SAMPLE_W;
    localparam int TYPES_W       = 2 * CHANNELS;

    localparam int TABLE_ENTRIES = 22;
    localparam int STORED        = 22;
    localparam int USED_ENTRIES  = (TABLE_ENTRIES > STORED) ? STORED : TABLE_ENTRIES;
    localparam int TOP_ENTRY     = (USED_ENTRIES == 0) ? 0 : USED_ENTRIES - 1;
    localparam int IDX_W         = $clog2(STORED);

    localparam logic [DIST_W-1:0]  LASER_GAIN   = 16'd39970;
    localparam logic [DIST_W-1:0]  LASER_OFFSET = 16'd56;
    localparam logic [DIST_W-1:0]  CM_TO_MM     = 16'd10;
    localparam logic [TYPES_W-1:0] TYPES_RESET  = 8'd170;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_READ   = 1'b1;

    localparam logic [1:0] TYPE_IR_A  = 2'd0;
    localparam logic [1:0] TYPE_IR_B  = 2'd1;
    localparam logic [1:0] TYPE_LASER = 2'd2;
    localparam logic [1:0] TYPE_NONE  = 2'd3;

    typedef logic [CHANNELS-1:0][1:0] t_types;

    localparam logic [CODE_W-1:0] IR_CODE [2][STORED] = '{
        '{8'd135, 8'd134, 8'd133, 8'd132, 8'd123, 8'd107, 8'd93, 8'd84, 8'd77, 8'd70,
          8'd58, 8'd49, 8'd43, 8'd38, 8'd34, 8'd31, 8'd29, 8'd27, 8'd25, 8'd23,
          8'd22, 8'd20},
        '{8'd163, 8'd147, 8'd137, 8'd127, 8'd117, 8'd107, 8'd91, 8'd81, 8'd77, 8'd66,
          8'd56, 8'd45, 8'd40, 8'd38, 8'd33, 8'd30, 8'd26, 8'd25, 8'd23, 8'd22,
          8'd21, 8'd20}
    };

    localparam logic [CM_W-1:0] IR_CM [2][STORED] = '{
        '{7'd9, 7'd9, 7'd9, 7'd9, 7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20,
          7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65, 7'd70,
          7'd75, 7'd80},
        '{7'd6, 7'd7, 7'd8, 7'd9, 7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20,
          7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65, 7'd70,
          7'd75, 7'd80}
    };

endpackage

### rtl/rsac_if.sv
// Valid/ready channel interfaces: input item, result item, configuration write.
// Depends on rsac_pkg for field widths.
interface rsac_in_if;
    import rsac_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    modport source (output valid, kind, channel, sample, input ready);
    modport sink   (input valid, kind, channel, sample, output ready);
endinterface

interface rsac_out_if;
    import rsac_pkg::*;
    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     channel_out;
    logic [SAMPLE_W-1:0] average;
    logic [DIST_W-1:0]   distance_mm;
    logic                type_known;
    modport source (output valid, channel_out, average, distance_mm, type_known,
                    input ready);
    modport sink   (input valid, channel_out, average, distance_mm, type_known,
                    output ready);
endinterface

interface rsac_cfg_if;
    import rsac_pkg::*;
    logic               valid;
    logic               ready;
    logic [TYPES_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/ranging_sensor_average_and_convert_core.sv
// Ranging sensor average and convert core: sample ring memory, averaging, conversion.
// Depends on rsac_pkg and the channel interfaces in rsac_if.sv.
//
//   port     role    item
//   i_item   sink    kind, channel, sample
//   o_res    source  channel_out, average, distance_mm, type_known
//   i_cfg    sink    sensor_types write
//
// Sample item: one write to the sample memory.
// Read item: sum the ring (one registered memory read per cycle), then average,
// then a laser step or an infrared table scan from the top entry down (one entry
// per cycle); an unknown type goes straight on to loading the output.
// Reset is synchronous; valid bits make unwritten memory entries read as zero.
// A result waits in the output register while the next items are accepted; a
// later read stalls in its last state until that register is free.
module ranging_sensor_average_and_convert_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsac_in_if.sink    i_item,
    rsac_out_if.source o_res,
    rsac_cfg_if.sink   i_cfg
);
    import rsac_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_CONV  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LASER = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [SAMPLE_W-1:0]  mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [SAMPLE_W-1:0]  r_rd_data;
    logic                 r_rd_ok;

    logic [2:0]           r_state, n_state;
    logic [POS_W-1:0]     r_pos [CHANNELS];
    t_types               r_types;
    logic [CH_W-1:0]      r_ch;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [SAMPLE_W-1:0]  r_avg, n_avg;
    logic [1:0]           r_type, n_type;
    logic [CODE_W-1:0]    r_code, n_code;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [DIST_W-1:0]    r_dist, n_dist;
    logic                 r_known, n_known;

    logic                 r_out_valid;
    logic [CH_W-1:0]      r_out_ch;
    logic [SAMPLE_W-1:0]  r_out_avg;
    logic [DIST_W-1:0]    r_out_dist;
    logic                 r_out_known;

    logic                 in_acc;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [SAMPLE_W-1:0]  rd_value;
    logic [SAMPLE_W-1:0]  sum_avg;
    logic [1:0]           ch_type;
    logic                 out_free;
    logic                 out_load;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign in_acc       = i_item.valid && i_item.ready;
    assign wr_en        = in_acc && (i_item.kind == KIND_SAMPLE);
    assign wr_addr      = {i_item.channel, r_pos[i_item.channel]};
    assign rd_addr      = {r_ch, r_cnt[POS_W-1:0]};
    assign rd_value     = r_rd_ok ? r_rd_data : '0;
    assign sum_avg      = SAMPLE_W'(r_sum / SUM_W'(SAMPLES));
    assign ch_type      = r_types[r_ch];
    assign out_free     = !r_out_valid || o_res.ready;
    assign out_load     = (r_state == S_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_item.sample;
        end
        r_rd_data <= mem[rd_addr];
        r_rd_ok   <= r_valid[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_avg   = r_avg;
        n_type  = r_type;
        n_code  = r_code;
        n_idx   = r_idx;
        n_prod  = r_prod;
        n_dist  = r_dist;
        n_known = r_known;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_item.kind == KIND_READ)) begin
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_cnt != '0) begin
                    n_sum = r_sum + SUM_W'(rd_value);
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SAMPLES)) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_avg  = sum_avg;
                n_type = ch_type;
                unique case (ch_type) inside
                    TYPE_IR_A, TYPE_IR_B: begin
                        n_code  = sum_avg[SAMPLE_W-1:2];
                        n_idx   = IDX_W'(TOP_ENTRY);
                        n_state = S_SCAN;
                    end
                    TYPE_LASER: begin
                        n_prod  = PROD_W'(LASER_GAIN) * PROD_W'(sum_avg);
                        n_state = S_LASER;
                    end
                    default: begin
                        n_dist  = '0;
                        n_known = 1'b0;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                if ((r_idx != '0) && (IR_CODE[r_type[0]][r_idx] < r_code)) begin
                    n_idx = r_idx - IDX_W'(1);
                end else begin
                    n_dist  = DIST_W'(IR_CM[r_type[0]][r_idx]) * CM_TO_MM;
                    n_known = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_LASER: begin
                n_dist  = DIST_W'(r_prod >> DIST_W) - LASER_OFFSET;
                n_known = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_types     <= TYPES_RESET;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_types <= i_cfg.data;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
                if (r_pos[i_item.channel] == POS_W'(SAMPLES - 1)) begin
                    r_pos[i_item.channel] <= '0;
                end else begin
                    r_pos[i_item.channel] <= r_pos[i_item.channel] + POS_W'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch <= i_item.channel;
        end
        r_cnt   <= n_cnt;
        r_sum   <= n_sum;
        r_avg   <= n_avg;
        r_type  <= n_type;
        r_code  <= n_code;
        r_idx   <= n_idx;
        r_prod  <= n_prod;
        r_dist  <= n_dist;
        r_known <= n_known;
        if (out_load) begin
            r_out_ch    <= r_ch;
            r_out_avg   <= r_avg;
            r_out_dist  <= r_dist;
            r_out_known <= r_known;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.channel_out = r_out_ch;
    assign o_res.average     = r_out_avg;
    assign o_res.distance_mm = r_out_dist;
    assign o_res.type_known  = r_out_known;

    a_sample_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_item.kind == KIND_SAMPLE)) |=> (r_state == S_IDLE))
        else $error("sample item did not finish in one cycle");

    a_sum_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && (r_cnt == CNT_W'(SAMPLES))) |=> (r_state == S_CONV))
        else $error("ring sum did not end after all samples");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result load did not present an item");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= IDX_W'(TOP_ENTRY)))
        else $error("table scan index out of range");

endmodule
